// ===== design/insertion_sorter_defines.svh =====
// ----------------------------------------------------------------------------
// insertion_sorter_defines
// assertion macros used by the insertion sorter
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ISRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("isrt check failed");

// next-cycle implication, checked outside reset
`define ISRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("isrt check failed");

`endif

// ===== design/isrt_pkg.sv =====
// ----------------------------------------------------------------------------
// isrt_pkg
// shared types for the insertion sorter cell chain
// ----------------------------------------------------------------------------
package isrt_pkg;

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctrl;

endpackage

// ===== design/isrt_node.sv =====
// ----------------------------------------------------------------------------
// isrt_node
// one cell of the sort chain: keeps one entry, inserts or shifts down
// ----------------------------------------------------------------------------
module isrt_node import isrt_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cell_ctrl                    i_ctrl,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic signed [VALUE_WIDTH-1:0] i_left_value,
    input  logic                          i_left_valid,
    input  logic                          i_left_gt,
    input  logic signed [VALUE_WIDTH-1:0] i_right_value,
    input  logic                          i_right_valid,
    output logic signed [VALUE_WIDTH-1:0] o_value,
    output logic                          o_valid,
    output logic                          o_gt
);

    logic signed [VALUE_WIDTH-1:0] r_value;
    logic signed [VALUE_WIDTH-1:0] n_value;
    logic                          r_valid;
    logic                          n_valid;

    // empty cells count as greater than anything
    assign o_gt = !r_valid || (r_value > i_value);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.shift) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_ctrl.ins && o_gt) begin
            n_value = i_left_gt ? i_left_value : i_value;
            n_valid = r_valid | i_left_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

// ===== design/insertion_sorter.sv =====
// ----------------------------------------------------------------------------
// insertion_sorter
// streaming insertion sort of one set of signed values over a chain of cells
// ----------------------------------------------------------------------------
// channel  dir  tdata       tlast     tuser
// s        in   in_value    in_last   -
// m        out  out_value   out_last  out_overflow
//
// one request is taken per cycle while filling, dropped if the chain is full; all cells compare at once
// after the request marked last, the chain drains one result per cycle
// input is held off while draining; a stalled output holds the chain
// sync active-low reset empties the chain; entries carry no reset
// ----------------------------------------------------------------------------
`include "insertion_sorter_defines.svh"

module insertion_sorter import isrt_pkg::*; #(
    parameter int CAPACITY    = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      i_s_tdata,  // in_value
    input  logic                                  i_s_tlast,  // in_last
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [((VALUE_WIDTH+7)/8)*8-1:0]      o_m_tdata,  // out_value
    output logic                                  o_m_tlast,  // out_last
    output logic                                  o_m_tuser   // out_overflow
);

    localparam int DataWidth = ((VALUE_WIDTH + 7) / 8) * 8;

    t_state                        r_state;
    t_state                        n_state;
    logic                          r_dropped;
    logic                          n_dropped;
    t_cell_ctrl                    w_ctrl;
    logic signed [VALUE_WIDTH-1:0] w_in_value;
    logic signed [VALUE_WIDTH-1:0] w_value [CAPACITY];
    logic [CAPACITY-1:0]           w_valid;
    logic [CAPACITY-1:0]           w_gt;
    logic                          w_in_acc;
    logic                          w_out_acc;
    logic                          w_full;

    assign w_in_value = $signed(i_s_tdata[VALUE_WIDTH-1:0]);
    assign w_full     = w_valid[CAPACITY-1];
    assign o_s_tready = (r_state == ST_FILL);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_state == ST_DRAIN);
    assign w_out_acc  = o_m_tvalid && i_m_tready;
    assign o_m_tdata  = DataWidth'($unsigned(w_value[0]));
    assign o_m_tlast  = !w_valid[1];
    assign o_m_tuser  = r_dropped;

    assign w_ctrl.ins   = w_in_acc && !w_full;
    assign w_ctrl.shift = w_out_acc;

    always_comb begin
        n_state   = r_state;
        n_dropped = r_dropped;
        unique case (r_state)
            ST_FILL: begin
                if (w_in_acc) begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_out_acc && o_m_tlast) begin
                    n_state   = ST_FILL;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FILL;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dropped <= n_dropped;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_chain
        logic signed [VALUE_WIDTH-1:0] w_left_value;
        logic                          w_left_valid;
        logic                          w_left_gt;
        logic signed [VALUE_WIDTH-1:0] w_right_value;
        logic                          w_right_valid;

        if (i == 0) begin : g_head
            assign w_left_value = w_in_value;
            assign w_left_valid = 1'b1;
            assign w_left_gt    = 1'b0;
        end else begin : g_body
            assign w_left_value = w_value[i-1];
            assign w_left_valid = w_valid[i-1];
            assign w_left_gt    = w_gt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_right_value = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right_value = w_value[i+1];
            assign w_right_valid = w_valid[i+1];
        end

        isrt_node #(
            .VALUE_WIDTH(VALUE_WIDTH)
        ) u_node (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_value      (w_in_value),
            .i_left_value (w_left_value),
            .i_left_valid (w_left_valid),
            .i_left_gt    (w_left_gt),
            .i_right_value(w_right_value),
            .i_right_valid(w_right_valid),
            .o_value      (w_value[i]),
            .o_valid      (w_valid[i]),
            .o_gt         (w_gt[i])
        );
    end

    // filled cells always form an unbroken run from the head
    `ISRT_ASSERT_NOW(a_valid_run, 1'b1, ((w_valid + 1'b1) & w_valid) == '0)
    `ISRT_ASSERT_NOW(a_drain_has_data, r_state == ST_DRAIN, w_valid[0])
    `ISRT_ASSERT_NOW(a_no_input_in_drain, o_m_tvalid, !o_s_tready)
    `ISRT_ASSERT_NEXT(a_end_clears, w_out_acc && o_m_tlast,
                      !w_valid[0] && !r_dropped && r_state == ST_FILL)

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the insertion sorter: sets of signed values go in,
// each closed by a request marked last, and every sorted result is compared
// field by field against a software sorted list kept by a small scoreboard
// ----------------------------------------------------------------------------
module tb;

    localparam int CAP       = 32;
    localparam int VAL_W     = 32;
    localparam int DATA_W    = ((VAL_W + 7) / 8) * 8;
    localparam int MAX_CYC   = 200000;
    localparam int TAIL_CYC  = 40;
    localparam int HOLD_CYC  = 300;
    localparam int NUM_ITEMS = 160;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             last;
        logic             ovf;
    } sorted_item_t;

    class sort_scoreboard;
        logic signed [VAL_W-1:0] sorted_list[$];
        bit                      dropped;
        sorted_item_t            sorted_pending[$];
        int                      errors;

        function void note_input(logic [VAL_W-1:0] v, logic l);
            int           pos;
            sorted_item_t it;
            if (sorted_list.size() < CAP) begin
                pos = sorted_list.size();
                while (pos > 0 && sorted_list[pos-1] > $signed(v))
                    pos--;
                sorted_list.insert(pos, $signed(v));
            end else begin
                dropped = 1'b1;
            end
            if (l) begin
                for (int k = 0; k < sorted_list.size(); k++) begin
                    it.value = sorted_list[k];
                    it.last  = (k == sorted_list.size() - 1);
                    it.ovf   = dropped;
                    sorted_pending.insert(sorted_pending.size(), it);
                end
                sorted_list.delete();
                dropped = 1'b0;
            end
        endfunction

        function void check_result(logic [DATA_W-1:0] v, logic l, logic u);
            sorted_item_t it;
            if (sorted_pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: value %0d last %b ovf %b",
                             $signed(v[VAL_W-1:0]), l, u);
                return;
            end
            it = sorted_pending.pop_front();
            if (v[VAL_W-1:0] !== it.value || l !== it.last || u !== it.ovf) begin
                errors++;
                if (errors <= 10)
                    $display("result error: exp %0d last %b ovf %b, got %0d last %b ovf %b",
                             $signed(it.value), it.last, it.ovf,
                             $signed(v[VAL_W-1:0]), l, u);
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata;   // in_value
    logic              i_s_tlast;   // in_last
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [DATA_W-1:0] o_m_tdata;   // out_value
    logic              o_m_tlast;   // out_last
    logic              o_m_tuser;   // out_overflow

    sort_scoreboard sb;
    int             cycle_cnt;
    int             sent;

    insertion_sorter #(
        .CAPACITY    (CAP),
        .VALUE_WIDTH (VAL_W)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYC) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // requests are noted before results at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                sb.note_input(i_s_tdata[VAL_W-1:0], i_s_tlast);
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tdata, o_m_tlast, o_m_tuser);
        end
    end

    task automatic send_value(input logic [VAL_W-1:0] v, input logic l);
        // no idling over a stretch in the middle of the run
        bit calm;
        calm = (sent >= 60 && sent < 110);
        while (!calm && $urandom_range(99) < 30) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= DATA_W'(v);
        i_s_tlast  <= l;
        do @(posedge i_clk); while (!o_s_tready);
        sent++;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(3))
            0, 1: v = $urandom;
            2:    v = VAL_W'($signed($urandom_range(8)) - 4);
            default: begin
                case ($urandom_range(5))
                    0: v = {1'b1, {(VAL_W-1){1'b0}}};
                    1: v = {1'b0, {(VAL_W-1){1'b1}}};
                    2: v = '0;
                    3: v = '1;
                    4: v = {1'b1, {(VAL_W-2){1'b0}}, 1'b1};
                    default: v = {1'b0, {(VAL_W-2){1'b1}}, 1'b0};
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_set(input int len);
        for (int k = 0; k < len; k++)
            send_value(pick_value(), k == len - 1);
    endtask

    // receiver: random stalls, one long hold-off, one calm stretch
    initial begin
        int  taken;
        bit  held;
        i_m_tready <= 1'b0;
        taken = 0;
        held  = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready)
                taken++;
            if (!held && taken >= 20) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYC) @(posedge i_clk);
            end else if (taken >= 80 && taken < 180) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(99) >= 30);
            end
        end
    end

    initial begin
        sb         = new();
        cycle_cnt  = 0;
        sent       = 0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tlast  <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-value sets at both extremes
        send_value(32'h7FFF_FFFF, 1'b1);
        send_value(32'h8000_0000, 1'b1);
        // extremes mixed with duplicates
        send_value(32'h0000_0000, 1'b0);
        send_value(32'hFFFF_FFFF, 1'b0);
        send_value(32'h7FFF_FFFF, 1'b0);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'h0000_0001, 1'b0);
        send_value(32'hFFFF_FFFF, 1'b0);
        send_value(32'h0000_0000, 1'b0);
        send_value(32'h0000_0005, 1'b1);
        // descending arrival, every value shifts the list
        for (int k = 4; k >= 0; k--)
            send_value(VAL_W'(k), k == 0);
        // ascending arrival, no shifting
        send_value(32'd10, 1'b0);
        send_value(32'd20, 1'b0);
        send_value(32'd30, 1'b1);
        // alternating bit patterns
        send_value(32'h5555_5555, 1'b0);
        send_value(32'hAAAA_AAAA, 1'b1);

        // exactly full, then overflow with last arriving on a full store
        send_set(CAP);
        send_set(CAP + 4);
        while (sent < NUM_ITEMS) begin
            if ($urandom_range(99) < 75)
                send_set($urandom_range(8, 1));
            else
                send_set($urandom_range(CAP + 8, CAP - 4));
        end
        i_s_tvalid <= 1'b0;
        i_s_tlast  <= 1'b0;

        // let the final request reach the scoreboard first
        @(posedge i_clk);
        while (sb.sorted_pending.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (sb.errors == 0 && sb.sorted_pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
